@@ rtl/hsv_to_rgb_converter_assert.svh @@
// ----------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Shared macros for the concurrent checks on the converter's ports.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define HSVRGB_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled during reset.
`define HSVRGB_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/hsvrgb_pkg.sv @@
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Fixed-point types, the unit level and the hue sector codes.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

   typedef logic [16:0] level_type;
   typedef logic [2:0]  sector_type;
   typedef logic [7:0]  channel_type;

   localparam level_type FIX_ONE = 17'h10000;

   localparam sector_type SECTOR_RED_YELLOW    = 3'd0;
   localparam sector_type SECTOR_YELLOW_GREEN  = 3'd1;
   localparam sector_type SECTOR_GREEN_CYAN    = 3'd2;
   localparam sector_type SECTOR_CYAN_BLUE     = 3'd3;
   localparam sector_type SECTOR_BLUE_MAGENTA  = 3'd4;
   localparam sector_type SECTOR_MAGENTA_RED   = 3'd5;

endpackage

@@ rtl/hsv_to_rgb_converter.sv @@
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Six-sector fixed-point conversion of hue, saturation and value to 8-bit RGB.
// The converter accepts one request every clock cycle unless a full pipeline
// is held by a stall on the result side. The pipeline has four register
// stages: hue splitting and clamping, the first rank of multipliers, the
// second rank of multipliers, and the sector selection with channel scaling
// into the output register. A stall on the result side fills the pipeline's
// empty stages before the request side is held, and nothing is dropped or
// repeated.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_hue,
   input  logic [16:0] req_saturation,
   input  logic [16:0] req_brightness,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue
);

   logic rdy1, rdy2, rdy3, rdy4;
   logic v1_ff, v2_ff, v3_ff, v4_ff;

   // Stage 1: sector, fraction and clamped inputs.
   logic [18:0]             hue6;
   hsvrgb_pkg::level_type   sat_in, val_in;
   hsvrgb_pkg::sector_type  sector1_ff;
   logic [15:0]             frac1_ff;
   hsvrgb_pkg::level_type   sat1_ff, val1_ff;

   // Stage 2: first rank of products.
   logic [33:0]             fs_prod, gs_prod, p_prod;
   hsvrgb_pkg::level_type   omf, oms;
   hsvrgb_pkg::sector_type  sector2_ff;
   hsvrgb_pkg::level_type   fs2_ff, gs2_ff, p2_ff, val2_ff;

   // Stage 3: second rank of products.
   logic [33:0]             q_prod, t_prod;
   hsvrgb_pkg::sector_type  sector3_ff;
   hsvrgb_pkg::level_type   p3_ff, q3_ff, t3_ff, val3_ff;

   // Stage 4: sector selection and scaling.
   hsvrgb_pkg::level_type   lvl_r, lvl_g, lvl_b;
   hsvrgb_pkg::channel_type red_in, green_in, blue_in;
   hsvrgb_pkg::channel_type red_ff, green_ff, blue_ff;

   assign rdy4      = !v4_ff || rsp_ready;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_ready = rdy1;

   assign hue6   = {1'b0, req_hue, 2'b00} + {2'b00, req_hue, 1'b0};
   assign sat_in = (req_saturation > hsvrgb_pkg::FIX_ONE) ? hsvrgb_pkg::FIX_ONE
                                                          : req_saturation;
   assign val_in = (req_brightness > hsvrgb_pkg::FIX_ONE) ? hsvrgb_pkg::FIX_ONE
                                                          : req_brightness;

   assign omf     = hsvrgb_pkg::FIX_ONE - {1'b0, frac1_ff};
   assign oms     = hsvrgb_pkg::FIX_ONE - sat1_ff;
   assign fs_prod = {1'b0, frac1_ff} * sat1_ff;
   assign gs_prod = omf * sat1_ff;
   assign p_prod  = val1_ff * oms;

   assign q_prod = val2_ff * (hsvrgb_pkg::FIX_ONE - fs2_ff);
   assign t_prod = val2_ff * (hsvrgb_pkg::FIX_ONE - gs2_ff);

   always_comb begin
      case (sector3_ff)
         hsvrgb_pkg::SECTOR_RED_YELLOW: begin
            lvl_r = val3_ff; lvl_g = t3_ff;   lvl_b = p3_ff;
         end
         hsvrgb_pkg::SECTOR_YELLOW_GREEN: begin
            lvl_r = q3_ff;   lvl_g = val3_ff; lvl_b = p3_ff;
         end
         hsvrgb_pkg::SECTOR_GREEN_CYAN: begin
            lvl_r = p3_ff;   lvl_g = val3_ff; lvl_b = t3_ff;
         end
         hsvrgb_pkg::SECTOR_CYAN_BLUE: begin
            lvl_r = p3_ff;   lvl_g = q3_ff;   lvl_b = val3_ff;
         end
         hsvrgb_pkg::SECTOR_BLUE_MAGENTA: begin
            lvl_r = t3_ff;   lvl_g = p3_ff;   lvl_b = val3_ff;
         end
         default: begin
            lvl_r = val3_ff; lvl_g = p3_ff;   lvl_b = q3_ff;
         end
      endcase
   end

   hsvrgb_scale u_scale_red   (.level(lvl_r), .channel(red_in));
   hsvrgb_scale u_scale_green (.level(lvl_g), .channel(green_in));
   hsvrgb_scale u_scale_blue  (.level(lvl_b), .channel(blue_in));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         sector1_ff <= hue6[18:16];
         frac1_ff   <= hue6[15:0];
         sat1_ff    <= sat_in;
         val1_ff    <= val_in;
      end
      if (rdy2) begin
         sector2_ff <= sector1_ff;
         fs2_ff     <= fs_prod[32:16];
         gs2_ff     <= gs_prod[32:16];
         p2_ff      <= p_prod[32:16];
         val2_ff    <= val1_ff;
      end
      if (rdy3) begin
         sector3_ff <= sector2_ff;
         p3_ff      <= p2_ff;
         q3_ff      <= q_prod[32:16];
         t3_ff      <= t_prod[32:16];
         val3_ff    <= val2_ff;
      end
      if (rdy4) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_valid = v4_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

endmodule

@@ rtl/hsvrgb_scale.sv @@
// ----------------------------------------------------------------------------
// HSV to RGB channel scaler
// Maps a level of 0 to 1.0 onto 0 to 255 as (level * 255) >> 16, truncated.
// ----------------------------------------------------------------------------
module hsvrgb_scale (
   input  hsvrgb_pkg::level_type   level,
   output hsvrgb_pkg::channel_type channel
);

   logic [24:0] product;

   assign product = {level, 8'd0} - {8'd0, level};
   assign channel = product[23:16];

endmodule

@@ rtl/hsvrgb_checker.sv @@
// ----------------------------------------------------------------------------
// HSV to RGB converter port checker
// Checks flow control and result holding as seen on the converter's ports.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_assert.svh"

module hsvrgb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_red,
   input logic [7:0] rsp_green,
   input logic [7:0] rsp_blue
);

   `HSVRGB_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue), "stalled result changed or vanished")
   `HSVRGB_ASSERT_IMPL(a_reset_empty, $past(reset), !rsp_valid, "result valid straight after reset")
   `HSVRGB_ASSERT_IMPL(a_full_when_held, !req_ready, rsp_valid && !rsp_ready, "request held while result side is free")
   `HSVRGB_ASSERT_IMPL(a_flow_through, rsp_ready, req_ready, "request held although results drain")

endmodule

bind hsv_to_rgb_converter hsvrgb_checker u_hsvrgb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_red   (rsp_red),
   .rsp_green (rsp_green),
   .rsp_blue  (rsp_blue)
);
